// ----- hw/rtl/cobs_frame_encoder_core_defines.svh -----
// assertion macros used by the encoder core rtl
`ifndef COBS_FRAME_ENCODER_CORE_DEFINES_SVH
`define COBS_FRAME_ENCODER_CORE_DEFINES_SVH

// generic form with explicit clock and active-low reset
`define COBSENC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// form used inside modules that have clk_i and rst_ni
`define COBSENC_ASSERT(lbl, prop, msg) \
  `COBSENC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/cobsenc_pkg.sv -----
package cobsenc_pkg;

  localparam int ByteW      = 8;
  localparam int DepthW     = 6;
  localparam int RunW       = 5;
  localparam int RepW       = RunW + 1;
  localparam int CfgIdxW    = 2;
  localparam int MaxResults = 64;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam logic [DepthW-1:0] MinDepth      = 6'd4;
  localparam logic [DepthW-1:0] DepthReset    = 6'd32;
  localparam logic [RunW-1:0]   RunMinLen     = 5'd2;
  localparam logic [ByteW-1:0]  RunCodeOffset = 8'd127;
  localparam logic [ByteW-1:0]  ZeroCode      = 8'h00;

  typedef enum logic [CfgIdxW-1:0] {
    CfgDelimiter  = 2'd0,
    CfgBlockDepth = 2'd1,
    CfgRunLength  = 2'd2,
    CfgRunByte    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OpEncode = 1'b0,
    OpFinish = 1'b1
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             last;
  } out_item_t;

  // sequencer to output stage
  typedef struct packed {
    logic             start;
    logic             emit;
    logic             close;
    logic [ByteW-1:0] data;
  } emit_req_t;

  // output stage to sequencer
  typedef struct packed {
    logic grant;
    logic held;
  } emit_rsp_t;

endpackage

// ----- hw/rtl/cobs_frame_encoder_core.sv -----
// Byte-stuffing frame encoder with optional run elimination.
// Input channel (in_valid_i / in_stall_o) carries one item: a data byte or
// a finish-frame command. Output channel (out_valid_o / out_stall_i) carries
// encoded bytes; last marks the final byte caused by an input item.
// Registers (delimiter, block depth, run length, run byte) are written over
// the cfg port; the user must write them only while the encoder is idle, as
// the block does not enforce it. cfg_ready_o is always high. A plain data
// byte that is only buffered yields nothing. Other items, once accepted, run
// a sequencer over the block buffer memory: a put decision per step (a
// stored byte, a flush started by a full block or a delimiter, or the check
// that no puts remain), a block flush of the code byte and then each
// buffered byte, the flush checks and the delimiter of a finish, and a last
// step handing the flagged final byte to the output register. Throughput is
// set by the single read port of the block buffer, one encoded byte per
// cycle while the receiver does not stall. Results appear one byte behind
// the sequencer, since each byte is held back until it is known whether it
// is the last of its item. A receiver stall freezes the sequencer once the
// output register and hold slot are both full, losing nothing; bytes past
// MaxResults (64) for one item are dropped. Reset empties the block, clears
// any pending run and restores register defaults at once, with no clearing pass.
`include "cobs_frame_encoder_core_defines.svh"

module cobs_frame_encoder_core #(
  parameter int MAX_DEPTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cobsenc_pkg::in_item_t               in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cobsenc_pkg::out_item_t              out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cobsenc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [cobsenc_pkg::ByteW-1:0]       cfg_data_i
);

  localparam int FillW = $clog2(MAX_DEPTH + 1);
  localparam int AddrW = $clog2(MAX_DEPTH);
  localparam logic [cobsenc_pkg::DepthW-1:0] MaxDepthV = cobsenc_pkg::DepthW'(MAX_DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PUT   = 8'b0000_0010,
    S_CODE  = 8'b0000_0100,
    S_DATA  = 8'b0000_1000,
    S_FIN1  = 8'b0001_0000,
    S_FIN2  = 8'b0010_0000,
    S_DELIM = 8'b0100_0000,
    S_LAST  = 8'b1000_0000
  } state_e;

  // configuration
  logic [cobsenc_pkg::ByteW-1:0]  delim_q;
  logic [cobsenc_pkg::DepthW-1:0] depth_q;
  logic [cobsenc_pkg::RunW-1:0]   runlen_q;
  logic [cobsenc_pkg::ByteW-1:0]  runbyte_q;

  // sequencer state
  state_e                         state_q, state_d, ret_q, ret_d;
  logic                           rc_q, rc_d;
  logic                           fin_q, fin_d;
  logic [cobsenc_pkg::ByteW-1:0]  byte_q, byte_d;
  logic [cobsenc_pkg::RepW-1:0]   rep_q, rep_d;
  logic [cobsenc_pkg::RunW-1:0]   pend_q, pend_d;
  logic [FillW-1:0]               fill_q, fill_d;
  logic [FillW-1:0]               idx_q, idx_d;

  // block buffer
  logic [cobsenc_pkg::ByteW-1:0]  mem [MAX_DEPTH];
  logic [cobsenc_pkg::ByteW-1:0]  rdata_q;
  logic                           we;
  logic [AddrW-1:0]               wa;
  logic [cobsenc_pkg::ByteW-1:0]  wd;

  cobsenc_pkg::emit_req_t         req;
  cobsenc_pkg::emit_rsp_t         rsp;

  logic [cobsenc_pkg::DepthW-1:0] eff;
  logic                           full;
  logic [cobsenc_pkg::ByteW-1:0]  fill8, code0, code;
  logic [cobsenc_pkg::ByteW-1:0]  put_byte;
  logic [cobsenc_pkg::RunW-1:0]   pend_inc;
  logic                           run_on;

  always_comb begin
    if (depth_q < cobsenc_pkg::MinDepth) begin
      eff = cobsenc_pkg::MinDepth;
    end else if (depth_q > MaxDepthV) begin
      eff = MaxDepthV;
    end else begin
      eff = depth_q;
    end
    full  = cobsenc_pkg::DepthW'(fill_q) >= eff;
    fill8 = cobsenc_pkg::ByteW'(fill_q);
    code0 = (delim_q != cobsenc_pkg::ZeroCode && fill8 == delim_q) ? cobsenc_pkg::ZeroCode
                                                                   : fill8;
    code  = rc_q ? code0 + cobsenc_pkg::RunCodeOffset : code0;
    // the item's own byte is the last put of a data transaction
    put_byte = (rep_q == cobsenc_pkg::RepW'(1) && !fin_q) ? byte_q : runbyte_q;
    pend_inc = pend_q + cobsenc_pkg::RunW'(1);
    run_on   = runlen_q >= cobsenc_pkg::RunMinLen;
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    rc_d      = rc_q;
    fin_d     = fin_q;
    byte_d    = byte_q;
    rep_d     = rep_q;
    pend_d    = pend_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    we        = 1'b0;
    wa        = fill_q[AddrW-1:0];
    wd        = put_byte;
    req.start = 1'b0;
    req.emit  = 1'b0;
    req.close = 1'b0;
    req.data  = code;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req.start = 1'b1;
          fin_d     = (in_item_i.operation == cobsenc_pkg::OpFinish);
          byte_d    = in_item_i.data_byte;
          if (in_item_i.operation == cobsenc_pkg::OpFinish) begin
            rep_d   = cobsenc_pkg::RepW'(pend_q);
            pend_d  = '0;
            state_d = S_PUT;
          end else if (run_on && in_item_i.data_byte == runbyte_q) begin
            if (pend_inc >= runlen_q) begin
              // complete run closes the block with the run code
              pend_d  = '0;
              rc_d    = 1'b1;
              ret_d   = S_LAST;
              state_d = S_CODE;
            end else begin
              pend_d = pend_inc;
            end
          end else if (pend_q != '0 && in_item_i.data_byte != runbyte_q) begin
            // broken run: replay it, then put the byte
            rep_d   = cobsenc_pkg::RepW'(pend_q) + cobsenc_pkg::RepW'(1);
            pend_d  = '0;
            state_d = S_PUT;
          end else if (!full && in_item_i.data_byte != delim_q) begin
            we     = 1'b1;
            wd     = in_item_i.data_byte;
            fill_d = fill_q + FillW'(1);
          end else begin
            rep_d   = cobsenc_pkg::RepW'(1);
            state_d = S_PUT;
          end
        end
      end
      S_PUT: begin
        if (rep_q == '0) begin
          state_d = fin_q ? S_FIN1 : S_LAST;
        end else if (full) begin
          rc_d    = 1'b0;
          ret_d   = S_PUT;
          state_d = S_CODE;
        end else if (put_byte != delim_q) begin
          we     = 1'b1;
          fill_d = fill_q + FillW'(1);
          rep_d  = rep_q - cobsenc_pkg::RepW'(1);
          if (rep_q == cobsenc_pkg::RepW'(1)) begin
            state_d = fin_q ? S_FIN1 : S_LAST;
          end
        end else begin
          rep_d   = rep_q - cobsenc_pkg::RepW'(1);
          rc_d    = 1'b0;
          ret_d   = S_PUT;
          state_d = S_CODE;
        end
      end
      S_CODE: begin
        req.emit = 1'b1;
        req.data = code;
        if (rsp.grant) begin
          if (fill_q == FillW'(1)) begin
            state_d = ret_q;
          end else begin
            idx_d   = FillW'(1);
            state_d = S_DATA;
          end
        end
      end
      S_DATA: begin
        req.emit = 1'b1;
        req.data = rdata_q;
        if (rsp.grant) begin
          if (idx_q + FillW'(1) >= fill_q) begin
            fill_d  = FillW'(1);
            state_d = ret_q;
          end else begin
            idx_d = idx_q + FillW'(1);
          end
        end
      end
      S_FIN1: begin
        rc_d  = 1'b0;
        if (full) begin
          ret_d   = S_FIN2;
          state_d = S_CODE;
        end else begin
          state_d = S_FIN2;
        end
      end
      S_FIN2: begin
        rc_d    = 1'b0;
        ret_d   = S_DELIM;
        state_d = S_CODE;
      end
      S_DELIM: begin
        req.emit = 1'b1;
        req.data = delim_q;
        if (rsp.grant) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        req.close = 1'b1;
        if (rsp.grant) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      rc_q      <= 1'b0;
      fin_q     <= 1'b0;
      rep_q     <= '0;
      pend_q    <= '0;
      fill_q    <= FillW'(1);
      idx_q     <= FillW'(1);
      delim_q   <= cobsenc_pkg::ZeroCode;
      depth_q   <= cobsenc_pkg::DepthReset;
      runlen_q  <= '0;
      runbyte_q <= cobsenc_pkg::ZeroCode;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rc_q    <= rc_d;
      fin_q   <= fin_d;
      rep_q   <= rep_d;
      pend_q  <= pend_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          cobsenc_pkg::CfgDelimiter:  delim_q   <= cfg_data_i;
          cobsenc_pkg::CfgBlockDepth: depth_q   <= cfg_data_i[cobsenc_pkg::DepthW-1:0];
          cobsenc_pkg::CfgRunLength:  runlen_q  <= cfg_data_i[cobsenc_pkg::RunW-1:0];
          cobsenc_pkg::CfgRunByte:    runbyte_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  // read address follows the next index so data is ready when the flush advances
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[idx_d[AddrW-1:0]];
  end

  cobsenc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  `COBSENC_ASSERT(a_idle_no_held, (state_q == S_IDLE) |-> !rsp.held, "held byte left while idle")
  `COBSENC_ASSERT(a_store_in_block, we |-> (cobsenc_pkg::DepthW'(fill_q) < eff), "store past block")
  `COBSENC_ASSERT(a_read_in_fill, (state_q == S_DATA) |-> (idx_q < fill_q), "flush index past fill")

endmodule

// ----- hw/rtl/cobsenc_out.sv -----
module cobsenc_out (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cobsenc_pkg::emit_req_t req_i,
  output cobsenc_pkg::emit_rsp_t rsp_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cobsenc_pkg::out_item_t out_item_o
);

  logic                         hv_q, hv_d;
  logic [cobsenc_pkg::ByteW-1:0] hb_q, hb_d;
  logic                         ov_q, ov_d;
  logic [cobsenc_pkg::ByteW-1:0] ob_q, ob_d;
  logic                         ol_q, ol_d;
  logic [cobsenc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                         free, grant, cap, load, load_last;

  // one byte is held back so the final byte of a transaction can be flagged
  always_comb begin
    free      = !ov_q || !out_stall_i;
    grant     = !hv_q || free;
    cap       = (cnt_q == cobsenc_pkg::CntW'(cobsenc_pkg::MaxResults));
    hv_d      = hv_q;
    hb_d      = hb_q;
    cnt_d     = cnt_q;
    load      = 1'b0;
    load_last = 1'b0;
    if (req_i.start) begin
      cnt_d = '0;
    end
    if (req_i.emit && grant && !cap) begin
      load  = hv_q;
      hb_d  = req_i.data;
      hv_d  = 1'b1;
      cnt_d = cnt_q + cobsenc_pkg::CntW'(1);
    end else if (req_i.close && grant && hv_q) begin
      load      = 1'b1;
      load_last = 1'b1;
      hv_d      = 1'b0;
    end
    ov_d = (ov_q && out_stall_i) || load;
    ob_d = load ? hb_q : ob_q;
    ol_d = load ? load_last : ol_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      ov_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      hv_q  <= hv_d;
      ov_q  <= ov_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hb_q <= hb_d;
    ob_q <= ob_d;
    ol_q <= ol_d;
  end

  assign rsp_o.grant         = grant;
  assign rsp_o.held          = hv_q;
  assign out_valid_o         = ov_q;
  assign out_item_o.out_byte = ob_q;
  assign out_item_o.last     = ol_q;

endmodule
